>>> src/assert_macros.svh
// assertion helpers for the sparse store
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSES_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sparse store assertion failed");
`define CSES_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("sparse store forbidden condition");
`else
`define CSES_ASSERT(lbl, prop)
`define CSES_NEVER(lbl, cond)
`endif
`endif

>>> src/cses_pkg.sv
// ----------------------------------------------------------------------------
// cses_pkg
// shared types and codes of the compressed sparse element store
// ----------------------------------------------------------------------------
`default_nettype none
package cses_pkg;

    localparam int IDX_W = 6;
    localparam int CFG_W = 7;
    localparam int IN_VAL_W = 32;
    localparam int ST_W = 2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OOB  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    localparam logic CFG_OUTER_SIZE = 1'b0;
    localparam logic CFG_INNER_SIZE = 1'b1;

    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_READ = 2'd1;
    localparam logic [1:0] RES_OOB  = 2'd2;
    localparam logic [1:0] RES_FULL = 2'd3;

    typedef struct packed {
        logic       latch;
        logic       seg_rd_lo;
        logic       seg_rd_hi;
        logic       scan_start;
        logic       scan_run;
        logic       shift_start;
        logic       shift_run;
        logic       put_new;
        logic       put_upd;
        logic       inc_run;
        logic       res_load;
        logic [1:0] res_sel;
    } cmd_t;

    typedef struct packed {
        logic is_write;
        logic oob;
        logic full;
        logic scan_hit;
        logic scan_miss;
        logic shift_done;
        logic inc_done;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

>>> src/cses_ram.sv
// ----------------------------------------------------------------------------
// cses_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module cses_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> src/cses_ctrl.sv
// ----------------------------------------------------------------------------
// cses_ctrl
// request sequencer: lookup, scan, update or insert, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cses_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire cses_pkg::stat_t stat,
    output cses_pkg::cmd_t      cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LO    = 4'd1;
    localparam logic [3:0] S_HI    = 4'd2;
    localparam logic [3:0] S_END   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_PUT   = 4'd7;
    localparam logic [3:0] S_INC   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kind_reg  <= cses_pkg::RES_ZERO;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        cmd         = '0;
        cmd.res_sel = kind_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_LO;
                end
            end
            S_LO: begin
                if (stat.oob) begin
                    kind_next  = cses_pkg::RES_OOB;
                    state_next = S_FIN;
                end else begin
                    cmd.seg_rd_lo = 1'b1;
                    state_next    = S_HI;
                end
            end
            S_HI: begin
                cmd.seg_rd_hi = 1'b1;
                state_next    = S_END;
            end
            S_END: begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_hit) begin
                    if (stat.is_write) begin
                        state_next = S_UPD;
                    end else begin
                        kind_next  = cses_pkg::RES_READ;
                        state_next = S_FIN;
                    end
                end else if (stat.scan_miss) begin
                    if (!stat.is_write) begin
                        kind_next  = cses_pkg::RES_ZERO;
                        state_next = S_FIN;
                    end else if (stat.full) begin
                        kind_next  = cses_pkg::RES_FULL;
                        state_next = S_FIN;
                    end else begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end
            end
            S_UPD: begin
                cmd.put_upd = 1'b1;
                kind_next   = cses_pkg::RES_ZERO;
                state_next  = S_FIN;
            end
            S_SHIFT: begin
                cmd.shift_run = 1'b1;
                if (stat.shift_done) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                cmd.put_new = 1'b1;
                state_next  = S_INC;
            end
            S_INC: begin
                cmd.inc_run = 1'b1;
                if (stat.inc_done) begin
                    kind_next  = cses_pkg::RES_ZERO;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!stat.out_busy) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `CSES_NEVER(a_one_entry_write, cmd.put_new && cmd.put_upd)
    `CSES_ASSERT(a_full_no_insert, (state_reg == S_SCAN) && stat.full |-> !cmd.shift_start)
    `CSES_ASSERT(a_oob_to_fin, (state_reg == S_LO) && stat.oob |=> state_reg == S_FIN)

endmodule
`default_nettype wire

>>> src/cses_dp.sv
// ----------------------------------------------------------------------------
// cses_dp
// datapath: config, request fields, pointer store, entry store, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cses_dp #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_OUTER   = 64,
    parameter int MAX_INNER   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wen,
    input  wire logic                        cfg_addr,
    input  wire logic [cses_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                        s_req_type,
    input  wire logic [cses_pkg::IDX_W-1:0]  s_outer_index,
    input  wire logic [cses_pkg::IDX_W-1:0]  s_inner_index,
    input  wire logic [cses_pkg::IN_VAL_W-1:0] s_write_value,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [cses_pkg::IN_VAL_W-1:0]    m_read_value,
    output logic [cses_pkg::ST_W-1:0]        m_status,
    input  wire cses_pkg::cmd_t              cmd,
    output cses_pkg::stat_t                  stat
);

    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int OAW = $clog2(MAX_OUTER + 1);
    localparam int IPW = OAW + 1;
    localparam int EW  = cses_pkg::IDX_W + VALUE_WIDTH;
    localparam int XW  = 13;

    logic [cses_pkg::CFG_W-1:0] outer_size_reg, inner_size_reg;
    logic                       wr_reg;
    logic [cses_pkg::IDX_W-1:0] oi_reg, ii_reg;
    logic [VALUE_WIDTH-1:0]     wv_reg, hit_val_reg;
    logic [CW-1:0]              start_reg, end_reg, count_reg, ptr_reg;
    logic                       pend_reg;
    logic [EAW-1:0]             pend_addr_reg, pos_reg;
    logic [MAX_OUTER:0]         seg_valid_reg;
    logic                       seg_vq_reg;
    logic [IPW-1:0]             inc_ptr_reg;
    logic                       inc_pend_reg;
    logic [OAW-1:0]             inc_addr_reg;
    logic                       m_valid_reg;
    logic [cses_pkg::IN_VAL_W-1:0] m_val_reg;
    logic [cses_pkg::ST_W-1:0]  m_st_reg;

    logic [XW-1:0]          eff_outer, eff_inner;
    logic [64:0]            wv_sx, hv_sx;
    logic [IPW-1:0]         oi_w, oi_w1;
    logic                   seg_re, seg_we;
    logic [OAW-1:0]         seg_raddr;
    logic [CW-1:0]          seg_rdata, seg_q, seg_wdata;
    logic                   ent_re, ent_we;
    logic [EAW-1:0]         ent_raddr, ent_waddr;
    logic [EW-1:0]          ent_rdata, ent_wdata;
    logic [CW-1:0]          ptr_dec;
    logic                   hit, scan_issue, shift_issue, inc_issue;

    assign eff_outer = (XW'(outer_size_reg) > XW'(MAX_OUTER)) ? XW'(MAX_OUTER)
                                                              : XW'(outer_size_reg);
    assign eff_inner = (XW'(inner_size_reg) > XW'(MAX_INNER)) ? XW'(MAX_INNER)
                                                              : XW'(inner_size_reg);
    assign wv_sx = {{33{s_write_value[cses_pkg::IN_VAL_W-1]}}, s_write_value};
    assign hv_sx = {{(65 - VALUE_WIDTH){hit_val_reg[VALUE_WIDTH-1]}}, hit_val_reg};
    assign oi_w  = IPW'(oi_reg);
    assign oi_w1 = oi_w + IPW'(1);
    assign seg_q = seg_vq_reg ? seg_rdata : '0;
    assign ptr_dec = ptr_reg - CW'(1);

    assign hit         = pend_reg && (ent_rdata[EW-1:VALUE_WIDTH] == ii_reg);
    assign scan_issue  = cmd.scan_run && !hit && (ptr_reg < end_reg);
    assign shift_issue = cmd.shift_run && (ptr_reg > end_reg);
    assign inc_issue   = cmd.inc_run && (inc_ptr_reg <= IPW'(MAX_OUTER));

    // pointer store access
    always_comb begin
        seg_re    = 1'b1;
        seg_raddr = oi_w[OAW-1:0];
        if (cmd.seg_rd_hi) begin
            seg_raddr = oi_w1[OAW-1:0];
        end else if (cmd.inc_run) begin
            seg_raddr = inc_ptr_reg[OAW-1:0];
            seg_re    = inc_issue;
        end else if (!cmd.seg_rd_lo) begin
            seg_re = 1'b0;
        end
        seg_we    = inc_pend_reg;
        seg_wdata = seg_q + CW'(1);
    end

    // entry store access
    always_comb begin
        ent_re    = scan_issue || shift_issue;
        ent_raddr = cmd.shift_run ? ptr_dec[EAW-1:0] : ptr_reg[EAW-1:0];
        ent_we    = 1'b0;
        ent_waddr = pend_addr_reg;
        ent_wdata = ent_rdata;
        if (cmd.put_upd) begin
            ent_we    = 1'b1;
            ent_waddr = pos_reg;
            ent_wdata = {ii_reg, wv_reg};
        end else if (cmd.put_new) begin
            ent_we    = 1'b1;
            ent_waddr = end_reg[EAW-1:0];
            ent_wdata = {ii_reg, wv_reg};
        end else if (cmd.shift_run && pend_reg) begin
            ent_we = 1'b1;
        end
    end

    cses_ram #(.WIDTH(CW), .DEPTH(MAX_OUTER + 1)) u_seg_ram (
        .aclk  (aclk),
        .we    (seg_we),
        .waddr (inc_addr_reg),
        .wdata (seg_wdata),
        .re    (seg_re),
        .raddr (seg_raddr),
        .rdata (seg_rdata)
    );

    cses_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ent_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outer_size_reg <= cses_pkg::CFG_W'(64);
            inner_size_reg <= cses_pkg::CFG_W'(64);
            seg_valid_reg  <= '0;
            count_reg      <= '0;
            pend_reg       <= 1'b0;
            inc_pend_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_addr)
                    cses_pkg::CFG_OUTER_SIZE: outer_size_reg <= cfg_wdata;
                    cses_pkg::CFG_INNER_SIZE: inner_size_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (seg_we) begin
                seg_valid_reg[inc_addr_reg] <= 1'b1;
            end
            if (cmd.put_new) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.scan_start || cmd.shift_start) begin
                pend_reg <= 1'b0;
            end else if (cmd.scan_run) begin
                pend_reg <= scan_issue;
            end else if (cmd.shift_run) begin
                pend_reg <= shift_issue;
            end
            inc_pend_reg <= inc_issue;
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            wr_reg <= s_req_type;
            oi_reg <= s_outer_index;
            ii_reg <= s_inner_index;
            wv_reg <= wv_sx[VALUE_WIDTH-1:0];
        end
        if (seg_re) begin
            seg_vq_reg <= seg_valid_reg[seg_raddr];
        end
        if (cmd.seg_rd_hi) begin
            start_reg <= seg_q;
        end
        if (cmd.scan_start) begin
            end_reg <= seg_q;
            ptr_reg <= start_reg;
        end else if (cmd.shift_start) begin
            ptr_reg <= count_reg;
        end else if (scan_issue) begin
            ptr_reg       <= ptr_reg + CW'(1);
            pend_addr_reg <= ptr_reg[EAW-1:0];
        end else if (shift_issue) begin
            ptr_reg       <= ptr_dec;
            pend_addr_reg <= ptr_reg[EAW-1:0];
        end
        if (cmd.scan_run && hit) begin
            pos_reg     <= pend_addr_reg;
            hit_val_reg <= ent_rdata[VALUE_WIDTH-1:0];
        end
        if (cmd.put_new) begin
            inc_ptr_reg <= oi_w1;
        end else if (inc_issue) begin
            inc_ptr_reg  <= inc_ptr_reg + IPW'(1);
            inc_addr_reg <= inc_ptr_reg[OAW-1:0];
        end
        if (cmd.res_load) begin
            unique case (cmd.res_sel)
                cses_pkg::RES_READ: begin
                    m_val_reg <= hv_sx[cses_pkg::IN_VAL_W-1:0];
                    m_st_reg  <= cses_pkg::ST_OK;
                end
                cses_pkg::RES_OOB: begin
                    m_val_reg <= '0;
                    m_st_reg  <= cses_pkg::ST_OOB;
                end
                cses_pkg::RES_FULL: begin
                    m_val_reg <= '0;
                    m_st_reg  <= cses_pkg::ST_FULL;
                end
                default: begin
                    m_val_reg <= '0;
                    m_st_reg  <= cses_pkg::ST_OK;
                end
            endcase
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_read_value = m_val_reg;
    assign m_status     = m_st_reg;

    always_comb begin
        stat.is_write   = wr_reg;
        stat.oob        = (XW'(oi_reg) >= eff_outer) || (XW'(ii_reg) >= eff_inner);
        stat.full       = (count_reg == CW'(MAX_ENTRIES));
        stat.scan_hit   = hit;
        stat.scan_miss  = !hit && !pend_reg && (ptr_reg >= end_reg);
        stat.shift_done = !pend_reg && (ptr_reg == end_reg);
        stat.inc_done   = !inc_pend_reg && (inc_ptr_reg > IPW'(MAX_OUTER));
        stat.out_busy   = m_valid_reg && !m_tready;
    end

    `CSES_ASSERT(a_count_bound, count_reg <= CW'(MAX_ENTRIES))
    `CSES_ASSERT(a_scan_in_seg, cmd.scan_run |-> ptr_reg <= end_reg)
    `CSES_NEVER(a_insert_full, cmd.put_new && stat.full)
    `CSES_NEVER(a_result_overrun, cmd.res_load && m_valid_reg && !m_tready)

endmodule
`default_nettype wire

>>> src/compressed_sparse_element_store_core.sv
// request flow: an out-of-bounds request goes straight to the result; a read or update
// scans the segment entries in turn; an insert adds a shift of the entries above the
// segment end and a sweep of the pointers above outer_index, each one entry per cycle
// throughput: one word in flight; the next word is taken the cycle after the result is
// registered; a stalled result holds the controller
// reset: synchronous active-low aresetn, sizes to 64, empty store, no clearing pass
// ----------------------------------------------------------------------------
// compressed_sparse_element_store_core
// sparse matrix element store with lookup, in-place update and ordered insert
// ----------------------------------------------------------------------------
`default_nettype none
module compressed_sparse_element_store_core #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_OUTER   = 64,
    parameter int MAX_INNER   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_addr,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // outer_index, inner_index, write_value, zero pad
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // read_value
    output logic [1:0]       m_tuser    // status
);

    cses_pkg::cmd_t  cmd;
    cses_pkg::stat_t stat;

    cses_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cses_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_OUTER   (MAX_OUTER),
        .MAX_INNER   (MAX_INNER),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_req_type    (s_tuser),
        .s_outer_index (s_tdata[5:0]),
        .s_inner_index (s_tdata[11:6]),
        .s_write_value (s_tdata[43:12]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_read_value  (m_tdata),
        .m_status      (m_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
`default_nettype wire

>>> dv/compressed_sparse_element_store_core_test.sv
// ----------------------------------------------------------------------------
// compressed_sparse_element_store_core_test
// self-checking bench for the sparse element store: a directed table, then
// random reads and writes under several size settings.
// every accepted word is predicted by a behavioral copy of the store, and the
// results are compared in order, with bursty input and a stalling receiver
// ----------------------------------------------------------------------------
`default_nettype none
module compressed_sparse_element_store_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ENTRIES = 1024;
    localparam int N_OUTER = 64;
    localparam int N_INNER = 64;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [31:0]               rv;
        logic [cses_pkg::ST_W-1:0] st;
    } result_t;

    typedef struct {
        bit              is_cfg;
        bit              cfg_a;
        bit [6:0]        cfg_v;
        bit              wr;
        bit [5:0]        oi;
        bit [5:0]        ii;
        bit [31:0]       wv;
        bit              known;
        result_t         res;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int          outer_sz, inner_sz;
    int          seg_start [N_OUTER+1];
    logic [5:0]  ent_idx [N_ENTRIES];
    logic [31:0] ent_val [N_ENTRIES];
    result_t     pending_results [$];
    row_t        stim_table [$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;

    always #5 aclk = ~aclk;

    compressed_sparse_element_store_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic result_t access_store(bit wr, bit [5:0] oi, bit [5:0] ii,
                                             bit [31:0] wv);
        result_t r;
        int eff_o, eff_i, cnt, lo, hi, pos;
        r.rv = '0;
        r.st = cses_pkg::ST_OK;
        eff_o = outer_sz > N_OUTER ? N_OUTER : outer_sz;
        eff_i = inner_sz > N_INNER ? N_INNER : inner_sz;
        if (oi >= eff_o || ii >= eff_i) begin
            r.st = cses_pkg::ST_OOB;
            return r;
        end
        cnt = seg_start[N_OUTER] > N_ENTRIES ? N_ENTRIES : seg_start[N_OUTER];
        lo = seg_start[oi];
        hi = seg_start[oi+1] > cnt ? cnt : seg_start[oi+1];
        pos = -1;
        for (int k = lo; k < hi; k++) begin
            if (pos < 0 && ent_idx[k] == ii) pos = k;
        end
        if (!wr) begin
            if (pos >= 0) r.rv = ent_val[pos];
            return r;
        end
        if (pos >= 0) begin
            ent_val[pos] = wv;
            return r;
        end
        if (cnt >= N_ENTRIES) begin
            r.st = cses_pkg::ST_FULL;
            return r;
        end
        for (int k = cnt; k > hi; k--) begin
            ent_idx[k] = ent_idx[k-1];
            ent_val[k] = ent_val[k-1];
        end
        ent_idx[hi] = ii;
        ent_val[hi] = wv;
        for (int k = oi + 1; k <= N_OUTER; k++) seg_start[k]++;
        return r;
    endfunction

    function automatic void add_req(bit wr, bit [5:0] oi, bit [5:0] ii, bit [31:0] wv,
                                    bit known = 0, bit [31:0] rv = 0,
                                    bit [1:0] st = cses_pkg::ST_OK);
        row_t r;
        r = '{default: 0};
        r.wr = wr; r.oi = oi; r.ii = ii; r.wv = wv;
        r.known = known; r.res.rv = rv; r.res.st = st;
        stim_table.push_back(r);
    endfunction

    function automatic void add_cfg(bit a, bit [6:0] v);
        row_t r;
        r = '{default: 0};
        r.is_cfg = 1; r.cfg_a = a; r.cfg_v = v;
        stim_table.push_back(r);
    endfunction

    task automatic send_word(bit wr, bit [5:0] oi, bit [5:0] ii, bit [31:0] wv,
                             bit known = 0, result_t typed = '0);
        result_t r;
        if (burst_left == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end else begin
            @(negedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= wr;
        s_tdata <= {4'b0, wv, ii, oi};
        do @(posedge aclk); while (!s_tready);
        r = access_store(wr, oi, ii, wv);
        pending_results.push_back(known ? typed : r);
    endtask

    task automatic write_size(bit a, bit [6:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        wait (pending_results.size() == 0);
        repeat (8) @(negedge aclk);
        cfg_wen <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        if (a == cses_pkg::CFG_OUTER_SIZE) outer_sz = v; else inner_sz = v;
    endtask

    task automatic random_phase(int n, int hot);
        bit wr;
        bit [5:0] oi, ii;
        int eff_o, eff_i;
        for (int k = 0; k < n; k++) begin
            eff_o = outer_sz > N_OUTER ? N_OUTER : (outer_sz == 0 ? 1 : outer_sz);
            eff_i = inner_sz > N_INNER ? N_INNER : (inner_sz == 0 ? 1 : inner_sz);
            wr = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
                oi = 6'($urandom); ii = 6'($urandom);
            end else begin
                oi = 6'($urandom_range(0, (hot < eff_o ? hot : eff_o) - 1));
                ii = 6'($urandom_range(0, (hot < eff_i ? hot : eff_i) - 1));
            end
            send_word(wr, oi, ii, $urandom);
        end
    endtask

    always @(negedge aclk) begin
        case ((cycles / 200) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ((cycles % 11) < 7);
        endcase
    end

    always @(posedge aclk) begin
        result_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[compressed_sparse_element_store_core] ERROR");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word rv=%h st=%0d", $realtime, m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.rv) begin
                    $display("%0t: read_value expected %h actual %h", $realtime, want.rv,
                             m_tdata);
                    errors++;
                end
                if (m_tuser !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $realtime, want.st,
                             m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        outer_sz = 64;
        inner_sz = 64;
        foreach (seg_start[k]) seg_start[k] = 0;

        add_req(0, 0, 0, 32'hFFFFFFFF, 1, 0, cses_pkg::ST_OK);
        add_req(1, 0, 0, 32'h7FFFFFFF, 1, 0, cses_pkg::ST_OK);
        add_req(0, 0, 0, 0, 1, 32'h7FFFFFFF, cses_pkg::ST_OK);
        add_req(1, 63, 63, 32'h80000000, 1, 0, cses_pkg::ST_OK);
        add_req(0, 63, 63, 0, 1, 32'h80000000, cses_pkg::ST_OK);
        add_req(1, 0, 0, 32'hFFFFFFFF);
        add_req(0, 0, 0, 0);
        add_req(0, 5, 5, 32'h12345678, 1, 0, cses_pkg::ST_OK);
        add_req(1, 5, 5, 32'h0);
        add_req(1, 5, 63, 32'h5A5A5A5A);
        add_req(1, 2, 7, 32'hA5A5A5A5);
        add_req(0, 5, 63, 0);
        add_req(0, 2, 7, 0);
        add_cfg(cses_pkg::CFG_OUTER_SIZE, 7'd1);
        add_cfg(cses_pkg::CFG_INNER_SIZE, 7'd1);
        add_req(1, 1, 0, 32'h1, 1, 0, cses_pkg::ST_OOB);
        add_req(0, 0, 1, 0, 1, 0, cses_pkg::ST_OOB);
        add_req(0, 0, 0, 0);
        add_cfg(cses_pkg::CFG_OUTER_SIZE, 7'd0);
        add_req(0, 0, 0, 0, 1, 0, cses_pkg::ST_OOB);
        add_cfg(cses_pkg::CFG_OUTER_SIZE, 7'd127);
        add_cfg(cses_pkg::CFG_INNER_SIZE, 7'd127);
        add_req(0, 63, 63, 0);
        add_req(1, 63, 0, 32'h00000001);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[k]) begin
            if (stim_table[k].is_cfg)
                write_size(stim_table[k].cfg_a, stim_table[k].cfg_v);
            else
                send_word(stim_table[k].wr, stim_table[k].oi, stim_table[k].ii,
                          stim_table[k].wv, stim_table[k].known, stim_table[k].res);
        end

        write_size(cses_pkg::CFG_OUTER_SIZE, 7'd64);
        write_size(cses_pkg::CFG_INNER_SIZE, 7'd64);
        random_phase(150, 8);
        write_size(cses_pkg::CFG_OUTER_SIZE, 7'd1);
        write_size(cses_pkg::CFG_INNER_SIZE, 7'd1);
        random_phase(40, 64);
        write_size(cses_pkg::CFG_OUTER_SIZE, 7'd127);
        write_size(cses_pkg::CFG_INNER_SIZE, 7'd127);
        random_phase(120, 64);
        write_size(cses_pkg::CFG_OUTER_SIZE, 7'd0);
        random_phase(20, 64);
        write_size(cses_pkg::CFG_OUTER_SIZE, 7'($urandom_range(1, 63)));
        write_size(cses_pkg::CFG_INNER_SIZE, 7'($urandom_range(1, 63)));
        random_phase(120, 6);
        write_size(cses_pkg::CFG_OUTER_SIZE, 7'd64);
        write_size(cses_pkg::CFG_INNER_SIZE, 7'd64);
        random_phase(110, 16);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("[compressed_sparse_element_store_core] OK");
        else
            $display("[compressed_sparse_element_store_core] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
